>>> src/glyph_tile_shelf_allocator_defines.svh
// Assertion macros used by the glyph tile shelf allocator checker.
`ifndef GLYPH_TILE_SHELF_ALLOCATOR_DEFINES_SVH
`define GLYPH_TILE_SHELF_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GTSA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gtsa: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define GTSA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gtsa: next-cycle check failed");

`endif

>>> src/gtsa_pkg.sv
// Shared constants, status codes, sequencer states and result type.
package gtsa_pkg;

  localparam int GTSA_ATLAS_DIM     = 1024;
  localparam int GTSA_TABLE_ENTRIES = 256;

  localparam int ID_W   = 32;
  localparam int TILE_W = 12;
  localparam int POS_W  = 10;
  localparam int SIZE_W = 11;
  localparam int STAT_W = 3;

  typedef enum logic [STAT_W-1:0] {
    ST_HIT        = 3'd0,
    ST_PLACED     = 3'd1,
    ST_MISS       = 3'd2,
    ST_BAD_RASTER = 3'd3,
    ST_TOO_LARGE  = 3'd4,
    ST_ATLAS_FULL = 3'd5,
    ST_TABLE_FULL = 3'd6
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_CHECK,
    S_SIZE_W,
    S_SIZE_H,
    S_WRAP,
    S_SHIFT,
    S_FIT,
    S_PLACE,
    S_DONE
  } state_t;

  typedef struct packed {
    status_t             status;
    logic [POS_W-1:0]    pos_x;
    logic [POS_W-1:0]    pos_y;
    logic [SIZE_W-1:0]   size_w;
    logic [SIZE_W-1:0]   size_h;
  } res_t;

endpackage

>>> src/gtsa_alu.sv
// Shared adder with an over-limit compare against the atlas edge.
module gtsa_alu #(
  parameter int AW    = 12,
  parameter int LIMIT = gtsa_pkg::GTSA_ATLAS_DIM
) (
  input  logic [AW-1:0] a,
  input  logic [AW-1:0] b,
  output logic [AW:0]   sum,
  output logic          over
);

  assign sum  = {1'b0, a} + {1'b0, b};
  assign over = sum > (AW+1)'(LIMIT);

endmodule

>>> src/gtsa_table.sv
// Glyph entry memory: id and rectangle per entry, one write and one registered read port.
module gtsa_table #(
  parameter int DEPTH = gtsa_pkg::GTSA_TABLE_ENTRIES,
  parameter int IW    = 8,
  parameter int DW    = 76
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [IW-1:0] rd_addr,
  output logic [DW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [IW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> src/gtsa_seq.sv
// Sequencer: table scan, miss checks, shelf wrap and placement through the shared adder.
module gtsa_seq #(
  parameter int TABLE_ENTRIES = gtsa_pkg::GTSA_TABLE_ENTRIES,
  parameter int CW            = 11,
  parameter int AW            = 12,
  parameter int IW            = 8,
  parameter int CNTW          = 9,
  parameter int DW            = 76
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_op,
  input  logic [gtsa_pkg::ID_W-1:0]     in_glyph_id,
  input  logic                          in_raster_ok,
  input  logic [gtsa_pkg::TILE_W-1:0]   in_tile_w,
  input  logic [gtsa_pkg::TILE_W-1:0]   in_tile_h,
  output logic [AW-1:0]                 alu_a,
  output logic [AW-1:0]                 alu_b,
  input  logic [AW:0]                   alu_sum,
  input  logic                          alu_over,
  output logic                          rd_en,
  output logic [IW-1:0]                 rd_addr,
  input  logic [DW-1:0]                 rd_data,
  output logic                          wr_en,
  output logic [IW-1:0]                 wr_addr,
  output logic [DW-1:0]                 wr_data,
  output gtsa_pkg::res_t                res,
  output logic                          res_valid,
  input  logic                          res_take
);

  import gtsa_pkg::*;

  state_t            state_r, state_nxt;
  logic              op_r, ok_r;
  logic [ID_W-1:0]   gid_r;
  logic [TILE_W-1:0] w_r, h_r;
  logic              load_in;

  logic [CW-1:0]     col_r, col_nxt;
  logic [CW:0]       top_r, top_nxt;
  logic [CW-1:0]     height_r, height_nxt;
  logic [CNTW-1:0]   count_r, count_nxt;
  logic [CNTW-1:0]   scan_r, scan_nxt;
  logic              pend_r, pend_nxt;
  res_t              res_r, res_nxt;

  logic [ID_W-1:0]   ent_id;
  logic [CW-1:0]     ent_x, ent_y, ent_w, ent_h;

  assign ent_id = rd_data[DW-1 -: ID_W];
  assign ent_x  = rd_data[4*CW-1 -: CW];
  assign ent_y  = rd_data[3*CW-1 -: CW];
  assign ent_w  = rd_data[2*CW-1 -: CW];
  assign ent_h  = rd_data[CW-1:0];

  assign rd_addr  = scan_r[IW-1:0];
  assign wr_addr  = count_r[IW-1:0];
  assign wr_data  = {gid_r, col_r, CW'(top_r), CW'(w_r), CW'(h_r)};
  assign in_stall = (state_r != S_IDLE) || !rst_n;
  assign res      = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      col_r    <= '0;
      top_r    <= '0;
      height_r <= '0;
      count_r  <= '0;
      scan_r   <= '0;
      pend_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      col_r    <= col_nxt;
      top_r    <= top_nxt;
      height_r <= height_nxt;
      count_r  <= count_nxt;
      scan_r   <= scan_nxt;
      pend_r   <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (load_in) begin
      op_r  <= in_op;
      gid_r <= in_glyph_id;
      ok_r  <= in_raster_ok;
      w_r   <= in_tile_w;
      h_r   <= in_tile_h;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    col_nxt    = col_r;
    top_nxt    = top_r;
    height_nxt = height_r;
    count_nxt  = count_r;
    scan_nxt   = scan_r;
    pend_nxt   = 1'b0;
    res_nxt    = res_r;
    alu_a      = '0;
    alu_b      = '0;
    rd_en      = 1'b0;
    wr_en      = 1'b0;
    res_valid  = 1'b0;
    load_in    = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          load_in   = 1'b1;
          scan_nxt  = '0;
          state_nxt = S_SCAN;
        end
      end

      // Compare the entry read last cycle while issuing the next read.
      S_SCAN: begin
        if (pend_r && ent_id == gid_r) begin
          res_nxt.status = ST_HIT;
          res_nxt.pos_x  = POS_W'(ent_x);
          res_nxt.pos_y  = POS_W'(ent_y);
          res_nxt.size_w = SIZE_W'(ent_w);
          res_nxt.size_h = SIZE_W'(ent_h);
          state_nxt      = S_DONE;
        end else if (scan_r < count_r) begin
          rd_en    = 1'b1;
          scan_nxt = scan_r + 1'b1;
          pend_nxt = 1'b1;
        end else begin
          state_nxt = S_CHECK;
        end
      end

      S_CHECK: begin
        res_nxt = '0;
        if (!op_r) begin
          res_nxt.status = ST_MISS;
          state_nxt      = S_DONE;
        end else if (!ok_r || w_r == '0 || h_r == '0) begin
          res_nxt.status = ST_BAD_RASTER;
          state_nxt      = S_DONE;
        end else begin
          state_nxt = S_SIZE_W;
        end
      end

      S_SIZE_W: begin
        alu_b = AW'(w_r);
        if (alu_over) begin
          res_nxt.status = ST_TOO_LARGE;
          state_nxt      = S_DONE;
        end else begin
          state_nxt = S_SIZE_H;
        end
      end

      S_SIZE_H: begin
        alu_b = AW'(h_r);
        if (alu_over) begin
          res_nxt.status = ST_TOO_LARGE;
          state_nxt      = S_DONE;
        end else begin
          state_nxt = S_WRAP;
        end
      end

      // Table full takes priority over the shelf wrap.
      S_WRAP: begin
        alu_a = AW'(col_r);
        alu_b = AW'(w_r);
        if (count_r >= CNTW'(TABLE_ENTRIES)) begin
          res_nxt.status = ST_TABLE_FULL;
          state_nxt      = S_DONE;
        end else if (alu_over) begin
          state_nxt = S_SHIFT;
        end else begin
          state_nxt = S_FIT;
        end
      end

      // Open a new shelf; this sticks even if the tile then fails to fit.
      S_SHIFT: begin
        alu_a      = AW'(top_r);
        alu_b      = AW'(height_r);
        top_nxt    = (CW+1)'(alu_sum);
        col_nxt    = '0;
        height_nxt = '0;
        state_nxt  = S_FIT;
      end

      S_FIT: begin
        alu_a = AW'(top_r);
        alu_b = AW'(h_r);
        if (alu_over) begin
          res_nxt.status = ST_ATLAS_FULL;
          state_nxt      = S_DONE;
        end else begin
          state_nxt = S_PLACE;
        end
      end

      S_PLACE: begin
        wr_en          = 1'b1;
        alu_a          = AW'(col_r);
        alu_b          = AW'(w_r);
        col_nxt        = CW'(alu_sum);
        count_nxt      = count_r + 1'b1;
        if (AW'(h_r) > AW'(height_r)) begin
          height_nxt = CW'(h_r);
        end
        res_nxt.status = ST_PLACED;
        res_nxt.pos_x  = POS_W'(col_r);
        res_nxt.pos_y  = POS_W'(top_r);
        res_nxt.size_w = SIZE_W'(w_r);
        res_nxt.size_h = SIZE_W'(h_r);
        state_nxt      = S_DONE;
      end

      // Hold the result until the output register is free.
      S_DONE: begin
        if (res_take) begin
          res_valid = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

>>> src/glyph_tile_shelf_allocator.sv
// A hit ends the scan at the matching entry; a miss scans every filled entry before the checks.
// The table scan reads one entry per cycle through a single memory read port.
// No new transaction is taken until the last result enters the output register, which frees input.
// Reset: synchronous, active low; clears the cursor, shelf and fill count, not the table.
// Entries beyond the fill count are never read, so no clearing pass follows reset.
module glyph_tile_shelf_allocator #(
  parameter int ATLAS_DIM     = gtsa_pkg::GTSA_ATLAS_DIM,
  parameter int TABLE_ENTRIES = gtsa_pkg::GTSA_TABLE_ENTRIES
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_op,
  input  logic [gtsa_pkg::ID_W-1:0]     in_glyph_id,
  input  logic                          in_raster_ok,
  input  logic [gtsa_pkg::TILE_W-1:0]   in_tile_w,
  input  logic [gtsa_pkg::TILE_W-1:0]   in_tile_h,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [gtsa_pkg::STAT_W-1:0]   out_status,
  output logic [gtsa_pkg::POS_W-1:0]    out_pos_x,
  output logic [gtsa_pkg::POS_W-1:0]    out_pos_y,
  output logic [gtsa_pkg::SIZE_W-1:0]   out_size_w,
  output logic [gtsa_pkg::SIZE_W-1:0]   out_size_h
);

  import gtsa_pkg::*;

  localparam int CW   = $clog2(ATLAS_DIM + 1);
  localparam int AW   = (CW + 1 > TILE_W) ? CW + 1 : TILE_W;
  localparam int IW   = $clog2(TABLE_ENTRIES);
  localparam int CNTW = $clog2(TABLE_ENTRIES + 1);
  localparam int DW   = ID_W + 4 * CW;

  logic [AW-1:0] alu_a, alu_b;
  logic [AW:0]   alu_sum;
  logic          alu_over;
  logic          rd_en, wr_en;
  logic [IW-1:0] rd_addr, wr_addr;
  logic [DW-1:0] rd_data, wr_data;
  res_t          res, out_res_r;
  logic          res_valid, res_take;
  logic          out_valid_r;

  gtsa_alu #(
    .AW    (AW),
    .LIMIT (ATLAS_DIM)
  ) u_alu (
    .a    (alu_a),
    .b    (alu_b),
    .sum  (alu_sum),
    .over (alu_over)
  );

  gtsa_table #(
    .DEPTH (TABLE_ENTRIES),
    .IW    (IW),
    .DW    (DW)
  ) u_table (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  gtsa_seq #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .CW            (CW),
    .AW            (AW),
    .IW            (IW),
    .CNTW          (CNTW),
    .DW            (DW)
  ) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_op        (in_op),
    .in_glyph_id  (in_glyph_id),
    .in_raster_ok (in_raster_ok),
    .in_tile_w    (in_tile_w),
    .in_tile_h    (in_tile_h),
    .alu_a        (alu_a),
    .alu_b        (alu_b),
    .alu_sum      (alu_sum),
    .alu_over     (alu_over),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .res          (res),
    .res_valid    (res_valid),
    .res_take     (res_take)
  );

  // Output register is free when empty or drained this cycle.
  assign res_take = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_res_r.status;
  assign out_pos_x  = out_res_r.pos_x;
  assign out_pos_y  = out_res_r.pos_y;
  assign out_size_w = out_res_r.size_w;
  assign out_size_h = out_res_r.size_h;

endmodule

>>> src/gtsa_checker.sv
// Port-level checker for the glyph tile shelf allocator, bound to the top level.
`include "glyph_tile_shelf_allocator_defines.svh"

module gtsa_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [gtsa_pkg::STAT_W-1:0]   out_status,
  input logic [gtsa_pkg::POS_W-1:0]    out_pos_x,
  input logic [gtsa_pkg::POS_W-1:0]    out_pos_y,
  input logic [gtsa_pkg::SIZE_W-1:0]   out_size_w,
  input logic [gtsa_pkg::SIZE_W-1:0]   out_size_h
);

  import gtsa_pkg::*;

  logic is_found;
  logic rect_zero;
  logic size_nonzero;

  assign is_found     = out_status == ST_HIT || out_status == ST_PLACED;
  assign rect_zero    = out_pos_x == '0 && out_pos_y == '0 &&
                        out_size_w == '0 && out_size_h == '0;
  assign size_nonzero = out_size_w != '0 && out_size_h != '0;

  // A result held under stall stays valid.
  `GTSA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)

  // The block goes busy once it takes a transaction.
  `GTSA_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)

  // Rejections carry an all-zero rectangle.
  `GTSA_ASSERT_NOW(a_reject_zero, clk, rst_n, out_valid && !is_found, rect_zero)

  // A placed or found tile is never empty.
  `GTSA_ASSERT_NOW(a_tile_nonempty, clk, rst_n, out_valid && is_found, size_nonzero)

endmodule

bind glyph_tile_shelf_allocator gtsa_checker u_gtsa_checker (.*);
